[rtl/core/uart_rx_ring_with_xon_xoff_rts_flow_assert.svh]
// Assertion macros for the checker of this block.
`ifndef UART_RX_RING_WITH_XON_XOFF_RTS_FLOW_ASSERT_SVH
`define UART_RX_RING_WITH_XON_XOFF_RTS_FLOW_ASSERT_SVH

// Concurrent assertion that is switched off while reset is active.
`define URXF_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also checks during reset.
`define URXF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/urxflow_pkg.sv]
package urxflow_pkg;

    // Receive ring geometry.
    localparam int DEPTH = 128;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    // Item kinds.
    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_SLOT = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_XOFF_LEVEL   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_XON_LEVEL    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_XON_CODE     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_XOFF_CODE    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_CODE    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_FLOW_EN = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD_FLOW_EN = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_EN      = 4'd7;

    // Register reset values.
    localparam logic [7:0] RST_XOFF_LEVEL = 8'd98;
    localparam logic [7:0] RST_XON_LEVEL  = 8'd30;
    localparam logic [7:0] RST_XON_CODE   = 8'h11;
    localparam logic [7:0] RST_XOFF_CODE  = 8'h13;
    localparam logic [7:0] RST_TERM_CODE  = 8'h0A;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_char;
        logic       tx_took_data;
        logic       read_valid;
        logic [7:0] read_char;
        logic       read_is_term;
        logic       rts_asserted;
        logic       overflow_seen;
        logic [7:0] fill_level;
    } t_result;

endpackage

[rtl/core/urxflow_if.sv]
interface urxflow_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data;
    logic       send_valid;
    logic       thr_empty;

    modport source (output valid, output kind, output data, output send_valid,
                    output thr_empty, input ready);
    modport sink   (input valid, input kind, input data, input send_valid,
                    input thr_empty, output ready);
endinterface

interface urxflow_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       tx_took_data;
    logic       read_valid;
    logic [7:0] read_char;
    logic       read_is_term;
    logic       rts_asserted;
    logic       overflow_seen;
    logic [7:0] fill_level;

    modport source (output valid, output tx_valid, output tx_char, output tx_took_data,
                    output read_valid, output read_char, output read_is_term,
                    output rts_asserted, output overflow_seen, output fill_level,
                    input ready);
    modport sink   (input valid, input tx_valid, input tx_char, input tx_took_data,
                    input read_valid, input read_char, input read_is_term,
                    input rts_asserted, input overflow_seen, input fill_level,
                    output ready);
endinterface

interface urxflow_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [urxflow_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/urxflow_ram.sv]
module urxflow_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/uart_rx_ring_with_xon_xoff_rts_flow.sv]
// Channel   Direction  Transaction
// i_in      sink       one item: received byte, transmit slot or host read
// o_out     source     one result per item: transmit, read and status fields
// i_cfg     sink       one register write, index and data; always ready
//
// The accept cycle updates pointers, fill count and flow-control marks and addresses
// the ring memory; the next cycle adds the registered read data and places the result
// in the output register. No new item is accepted while one is in progress.
// Reset is synchronous, reloads register reset values and clears the marks; the ring
// needs no clearing. A stalled result moves to a skid register, and the next item is
// accepted once the skid register is empty.
module uart_rx_ring_with_xon_xoff_rts_flow (
    input logic           i_clk,
    input logic           i_rst_n,
    urxflow_in_if.sink    i_in,
    urxflow_out_if.source o_out,
    urxflow_cfg_if.sink   i_cfg
);

    localparam int PTR_W = urxflow_pkg::PTR_W;
    localparam int CNT_W = urxflow_pkg::CNT_W;
    localparam int CMP_W = urxflow_pkg::CMP_W;

    logic [7:0] r_xoff_level, r_xon_level, r_xon_code, r_xoff_code, r_term_code;
    logic       r_soft_flow_en, r_hard_flow_en, r_term_en;

    logic [PTR_W-1:0] r_wptr, n_wptr, r_rptr, n_rptr;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic r_xoff_sent, n_xoff_sent, r_xoff_pend, n_xoff_pend, r_xon_pend, n_xon_pend;
    logic r_rts_off, n_rts_off, r_ovf, n_ovf;

    logic                 r_busy;
    urxflow_pkg::t_result r_res, n_res, res_now;
    urxflow_pkg::t_result r_out, r_skid;
    logic                 r_out_valid, r_skid_valid;

    logic       in_acc, out_free;
    logic       ram_we, ram_re;
    logic [7:0] ram_q;

    assign i_in.ready  = !r_busy && !r_skid_valid;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_out_valid || o_out.ready;

    urxflow_ram #(
        .WIDTH (8),
        .DEPTH (urxflow_pkg::DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (i_in.data),
        .i_re    (ram_re),
        .i_raddr (r_rptr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_wptr      = r_wptr;
        n_rptr      = r_rptr;
        n_fill      = r_fill;
        n_xoff_sent = r_xoff_sent;
        n_xoff_pend = r_xoff_pend;
        n_xon_pend  = r_xon_pend;
        n_rts_off   = r_rts_off;
        n_ovf       = r_ovf;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        n_res       = '0;
        if (in_acc) begin
            case (i_in.kind)
                urxflow_pkg::KIND_RX: begin
                    if (r_fill != CNT_W'(urxflow_pkg::DEPTH)) begin
                        ram_we = 1'b1;
                        n_wptr = (r_wptr == PTR_W'(urxflow_pkg::DEPTH - 1)) ? '0
                                                                           : r_wptr + 1'b1;
                        n_fill = r_fill + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (CMP_W'(n_fill) > CMP_W'(r_xoff_level)) begin
                        if (r_hard_flow_en) begin
                            n_rts_off = 1'b1;
                        end
                        if (r_soft_flow_en && !r_xoff_sent) begin
                            if (i_in.thr_empty) begin
                                n_res.tx_valid = 1'b1;
                                n_res.tx_char  = r_xoff_code;
                                n_xoff_sent    = 1'b1;
                            end else begin
                                n_xoff_pend = 1'b1;
                            end
                        end
                    end
                end
                urxflow_pkg::KIND_SLOT: begin
                    // Pending XOFF and XON cancel each other without a send.
                    if (r_xoff_pend && r_xon_pend) begin
                        n_xoff_pend = 1'b0;
                        n_xon_pend  = 1'b0;
                    end else if (r_xoff_pend) begin
                        n_res.tx_valid = 1'b1;
                        n_res.tx_char  = r_xoff_code;
                        n_xoff_sent    = 1'b1;
                        n_xoff_pend    = 1'b0;
                    end else if (r_xon_pend) begin
                        n_res.tx_valid = 1'b1;
                        n_res.tx_char  = r_xon_code;
                        n_xon_pend     = 1'b0;
                    end else if (i_in.send_valid) begin
                        n_res.tx_valid     = 1'b1;
                        n_res.tx_char      = i_in.data;
                        n_res.tx_took_data = 1'b1;
                    end
                end
                urxflow_pkg::KIND_READ: begin
                    if (r_fill != '0) begin
                        ram_re           = 1'b1;
                        n_rptr = (r_rptr == PTR_W'(urxflow_pkg::DEPTH - 1)) ? '0
                                                                           : r_rptr + 1'b1;
                        n_fill           = r_fill - 1'b1;
                        n_res.read_valid = 1'b1;
                    end
                    if (CMP_W'(n_fill) < CMP_W'(r_xon_level)) begin
                        n_xoff_pend = 1'b0;
                        n_rts_off   = 1'b0;
                        if (r_xoff_sent) begin
                            if (i_in.thr_empty) begin
                                n_res.tx_valid = 1'b1;
                                n_res.tx_char  = r_xon_code;
                            end else begin
                                n_xon_pend = 1'b1;
                            end
                            n_xoff_sent = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        n_res.rts_asserted  = !n_rts_off;
        n_res.overflow_seen = n_ovf;
        n_res.fill_level    = 8'(n_fill);
    end

    // The ring data arrives in the cycle after the read was addressed.
    always_comb begin
        res_now              = r_res;
        res_now.read_char    = r_res.read_valid ? ram_q : 8'h00;
        res_now.read_is_term = r_res.read_valid && r_term_en && (ram_q == r_term_code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xoff_level   <= urxflow_pkg::RST_XOFF_LEVEL;
            r_xon_level    <= urxflow_pkg::RST_XON_LEVEL;
            r_xon_code     <= urxflow_pkg::RST_XON_CODE;
            r_xoff_code    <= urxflow_pkg::RST_XOFF_CODE;
            r_term_code    <= urxflow_pkg::RST_TERM_CODE;
            r_soft_flow_en <= 1'b1;
            r_hard_flow_en <= 1'b1;
            r_term_en      <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                urxflow_pkg::CFG_XOFF_LEVEL:   r_xoff_level   <= i_cfg.data;
                urxflow_pkg::CFG_XON_LEVEL:    r_xon_level    <= i_cfg.data;
                urxflow_pkg::CFG_XON_CODE:     r_xon_code     <= i_cfg.data;
                urxflow_pkg::CFG_XOFF_CODE:    r_xoff_code    <= i_cfg.data;
                urxflow_pkg::CFG_TERM_CODE:    r_term_code    <= i_cfg.data;
                urxflow_pkg::CFG_SOFT_FLOW_EN: r_soft_flow_en <= i_cfg.data[0];
                urxflow_pkg::CFG_HARD_FLOW_EN: r_hard_flow_en <= i_cfg.data[0];
                urxflow_pkg::CFG_TERM_EN:      r_term_en      <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr       <= '0;
            r_rptr       <= '0;
            r_fill       <= '0;
            r_xoff_sent  <= 1'b0;
            r_xoff_pend  <= 1'b0;
            r_xon_pend   <= 1'b0;
            r_rts_off    <= 1'b0;
            r_ovf        <= 1'b0;
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_fill      <= n_fill;
            r_xoff_sent <= n_xoff_sent;
            r_xoff_pend <= n_xoff_pend;
            r_xon_pend  <= n_xon_pend;
            r_rts_off   <= n_rts_off;
            r_ovf       <= n_ovf;
            r_busy      <= in_acc;
            if (r_busy) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_free) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
        if (r_busy && out_free) begin
            r_out <= res_now;
        end else if (r_busy) begin
            r_skid <= res_now;
        end else if (out_free && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.tx_valid      = r_out.tx_valid;
    assign o_out.tx_char       = r_out.tx_char;
    assign o_out.tx_took_data  = r_out.tx_took_data;
    assign o_out.read_valid    = r_out.read_valid;
    assign o_out.read_char     = r_out.read_char;
    assign o_out.read_is_term  = r_out.read_is_term;
    assign o_out.rts_asserted  = r_out.rts_asserted;
    assign o_out.overflow_seen = r_out.overflow_seen;
    assign o_out.fill_level    = r_out.fill_level;

endmodule

[rtl/core/urxflow_checker.sv]
`include "uart_rx_ring_with_xon_xoff_rts_flow_assert.svh"

module urxflow_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_overflow_seen
);

    logic r_ovf_delivered;

    // Remembers that a delivered result has already reported an overflow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_delivered <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_overflow_seen) begin
            r_ovf_delivered <= 1'b1;
        end
    end

    `URXF_ASSERT_RST(a_ovf_sticky, i_clk, i_rst_n, (i_out_valid && r_ovf_delivered) |-> i_overflow_seen, "overflow flag cleared after it was reported")
    `URXF_ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "input ready while an item is still in progress")
    `URXF_ASSERT_ALWAYS(a_reset_empties_out, i_clk, !i_rst_n |=> !i_out_valid, "result shown right after reset")
    `URXF_ASSERT_RST(a_out_held, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "result withdrawn before its transaction")

endmodule

bind uart_rx_ring_with_xon_xoff_rts_flow urxflow_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_overflow_seen (o_out.overflow_seen)
);

[sim/uart_rx_ring_with_xon_xoff_rts_flow_test.sv]
`timescale 1ns / 1ps

module uart_rx_ring_with_xon_xoff_rts_flow_test;

    localparam int DEPTH     = urxflow_pkg::DEPTH;
    localparam int PTR_W     = urxflow_pkg::PTR_W;
    localparam int CFG_IDX_W = urxflow_pkg::CFG_IDX_W;

    localparam logic [1:0]           KIND_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd15;
    localparam int                   STALL_LIMIT   = 2000;
    localparam int                   DIR_SPLIT     = 11;
    localparam int                   PHASES        = 8;
    localparam int                   PHASE_ITEMS   = 125;

    typedef struct {
        logic [1:0]           kind;
        logic [7:0]           data;
        logic                 send_valid;
        logic                 thr_empty;
        bit                   typed;
        urxflow_pkg::t_result want;
    } t_rx_row;

    logic i_clk;
    logic i_rst_n;

    urxflow_in_if  rx_in();
    urxflow_out_if res_out();
    urxflow_cfg_if cfg_wr();

    uart_rx_ring_with_xon_xoff_rts_flow u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (rx_in),
        .o_out   (res_out),
        .i_cfg   (cfg_wr)
    );

    // Shadow copy of the block's registers and flow-control state.
    logic [7:0]       lvl_xoff, lvl_xon, chr_xon, chr_xoff, chr_term;
    logic             en_soft, en_hard, en_term;
    logic [7:0]       ring_mem [DEPTH];
    logic [PTR_W-1:0] wr_idx, rd_idx;
    int               held;
    bit               xoff_out, xoff_due, xon_due, rts_dropped, overrun;

    urxflow_pkg::t_result due_results[$];
    t_rx_row              plan[$];
    bit                   pin_typed;
    urxflow_pkg::t_result pin_want;
    bit                   calm;
    bit                   failed;
    int                   idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic urxflow_pkg::t_result pack_result(logic tv, logic [7:0] tc, logic took,
                                                         logic rv, logic [7:0] rc, logic rt,
                                                         logic rts, logic ovf,
                                                         logic [7:0] fill);
        urxflow_pkg::t_result r;
        r.tx_valid      = tv;
        r.tx_char       = tc;
        r.tx_took_data  = took;
        r.read_valid    = rv;
        r.read_char     = rc;
        r.read_is_term  = rt;
        r.rts_asserted  = rts;
        r.overflow_seen = ovf;
        r.fill_level    = fill;
        return r;
    endfunction

    function automatic void clear_flow_state();
        lvl_xoff    = urxflow_pkg::RST_XOFF_LEVEL;
        lvl_xon     = urxflow_pkg::RST_XON_LEVEL;
        chr_xon     = urxflow_pkg::RST_XON_CODE;
        chr_xoff    = urxflow_pkg::RST_XOFF_CODE;
        chr_term    = urxflow_pkg::RST_TERM_CODE;
        en_soft     = 1'b1;
        en_hard     = 1'b1;
        en_term     = 1'b1;
        wr_idx      = '0;
        rd_idx      = '0;
        held        = 0;
        xoff_out    = 1'b0;
        xoff_due    = 1'b0;
        xon_due     = 1'b0;
        rts_dropped = 1'b0;
        overrun     = 1'b0;
    endfunction

    // Applies one item to the shadow state and returns the status the block should report.
    function automatic urxflow_pkg::t_result flow_step(logic [1:0] kind, logic [7:0] data,
                                                       logic send_valid, logic thr_empty);
        urxflow_pkg::t_result r;
        r = '0;
        case (kind)
            urxflow_pkg::KIND_RX: begin
                if (held < DEPTH) begin
                    ring_mem[wr_idx] = data;
                    wr_idx = (wr_idx == PTR_W'(DEPTH - 1)) ? '0 : wr_idx + 1'b1;
                    held++;
                end else begin
                    overrun = 1'b1;
                end
                if (held > int'(lvl_xoff)) begin
                    if (en_hard) rts_dropped = 1'b1;
                    if (en_soft && !xoff_out) begin
                        if (thr_empty) begin
                            r.tx_valid = 1'b1;
                            r.tx_char  = chr_xoff;
                            xoff_out   = 1'b1;
                        end else begin
                            xoff_due = 1'b1;
                        end
                    end
                end
            end
            urxflow_pkg::KIND_SLOT: begin
                if (xoff_due && xon_due) begin
                    // Opposite control characters cancel without a transmission.
                    xoff_due = 1'b0;
                    xon_due  = 1'b0;
                end else if (xoff_due) begin
                    r.tx_valid = 1'b1;
                    r.tx_char  = chr_xoff;
                    xoff_out   = 1'b1;
                    xoff_due   = 1'b0;
                end else if (xon_due) begin
                    r.tx_valid = 1'b1;
                    r.tx_char  = chr_xon;
                    xon_due    = 1'b0;
                end else if (send_valid) begin
                    r.tx_valid     = 1'b1;
                    r.tx_char      = data;
                    r.tx_took_data = 1'b1;
                end
            end
            urxflow_pkg::KIND_READ: begin
                if (held > 0) begin
                    r.read_valid   = 1'b1;
                    r.read_char    = ring_mem[rd_idx];
                    r.read_is_term = en_term && (r.read_char == chr_term);
                    rd_idx = (rd_idx == PTR_W'(DEPTH - 1)) ? '0 : rd_idx + 1'b1;
                    held--;
                end
                if (held < int'(lvl_xon)) begin
                    xoff_due    = 1'b0;
                    rts_dropped = 1'b0;
                    if (xoff_out) begin
                        if (thr_empty) begin
                            r.tx_valid = 1'b1;
                            r.tx_char  = chr_xon;
                        end else begin
                            xon_due = 1'b1;
                        end
                        xoff_out = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        r.rts_asserted  = !rts_dropped;
        r.overflow_seen = overrun;
        r.fill_level    = held[7:0];
        return r;
    endfunction

    task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        urxflow_pkg::t_result want;
        bit                   moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (res_out.valid === 1'b1 && res_out.ready === 1'b1) begin
                moved = 1'b1;
                if (due_results.size() == 0) begin
                    $error("result transaction arrived with no item outstanding");
                    failed = 1'b1;
                end else begin
                    want = due_results.pop_front();
                    check_field("tx_valid", 8'(want.tx_valid), 8'(res_out.tx_valid));
                    check_field("tx_char", want.tx_char, res_out.tx_char);
                    check_field("tx_took_data", 8'(want.tx_took_data),
                                8'(res_out.tx_took_data));
                    check_field("read_valid", 8'(want.read_valid), 8'(res_out.read_valid));
                    check_field("read_char", want.read_char, res_out.read_char);
                    check_field("read_is_term", 8'(want.read_is_term),
                                8'(res_out.read_is_term));
                    check_field("rts_asserted", 8'(want.rts_asserted),
                                8'(res_out.rts_asserted));
                    check_field("overflow_seen", 8'(want.overflow_seen),
                                8'(res_out.overflow_seen));
                    check_field("fill_level", want.fill_level, res_out.fill_level);
                end
            end
            if (cfg_wr.valid && cfg_wr.ready === 1'b1) begin
                moved = 1'b1;
                case (cfg_wr.index)
                    urxflow_pkg::CFG_XOFF_LEVEL:   lvl_xoff = cfg_wr.data;
                    urxflow_pkg::CFG_XON_LEVEL:    lvl_xon  = cfg_wr.data;
                    urxflow_pkg::CFG_XON_CODE:     chr_xon  = cfg_wr.data;
                    urxflow_pkg::CFG_XOFF_CODE:    chr_xoff = cfg_wr.data;
                    urxflow_pkg::CFG_TERM_CODE:    chr_term = cfg_wr.data;
                    urxflow_pkg::CFG_SOFT_FLOW_EN: en_soft  = cfg_wr.data[0];
                    urxflow_pkg::CFG_HARD_FLOW_EN: en_hard  = cfg_wr.data[0];
                    urxflow_pkg::CFG_TERM_EN:      en_term  = cfg_wr.data[0];
                    default: ;
                endcase
            end
            if (rx_in.valid && rx_in.ready === 1'b1) begin
                moved = 1'b1;
                want = flow_step(rx_in.kind, rx_in.data, rx_in.send_valid, rx_in.thr_empty);
                due_results.push_back(pin_typed ? pin_want : want);
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    // Mostly short gaps, now and then a long one, none at all while calm is set.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        int stall_left;
        res_out.ready = 1'b1;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_out.ready = 1'b0;
                stall_left--;
            end else begin
                res_out.ready = 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic send_item(logic [1:0] kind, logic [7:0] data, logic send_valid,
                             logic thr_empty, bit typed, urxflow_pkg::t_result want);
        int gap;
        pin_typed        = typed;
        pin_want         = want;
        rx_in.kind       = kind;
        rx_in.data       = data;
        rx_in.send_valid = send_valid;
        rx_in.thr_empty  = thr_empty;
        rx_in.valid      = 1'b1;
        do @(posedge i_clk); while (rx_in.ready !== 1'b1);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            rx_in.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] index, logic [7:0] value);
        cfg_wr.index = index;
        cfg_wr.data  = value;
        cfg_wr.valid = 1'b1;
        do @(posedge i_clk); while (cfg_wr.ready !== 1'b1);
        @(negedge i_clk);
        cfg_wr.valid = 1'b0;
    endtask

    task automatic wait_idle();
        rx_in.valid = 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic void add_row(logic [1:0] kind, logic [7:0] data, logic send_valid,
                                    logic thr_empty, bit typed, urxflow_pkg::t_result want);
        t_rx_row row;
        row.kind       = kind;
        row.data       = data;
        row.send_valid = send_valid;
        row.thr_empty  = thr_empty;
        row.typed      = typed;
        row.want       = want;
        plan.push_back(row);
    endfunction

    task automatic program_phase(int phase);
        logic [7:0] xo, xn, c_on, c_off, c_term;
        logic       s, h, t;
        c_on   = 8'($urandom_range(0, 255));
        c_off  = 8'($urandom_range(0, 255));
        c_term = 8'($urandom_range(0, 255));
        s = 1'b1;
        h = 1'b1;
        t = 1'b1;
        case (phase)
            0: begin
                xo = urxflow_pkg::RST_XOFF_LEVEL;
                xn = urxflow_pkg::RST_XON_LEVEL;
            end
            1: begin
                xo = 8'd0;
                xn = 8'd0;
                c_on   = 8'h00;
                c_off  = 8'h00;
                c_term = 8'h00;
            end
            2: begin
                xo = 8'(DEPTH);
                xn = 8'(DEPTH);
                c_on   = 8'hFF;
                c_off  = 8'hFF;
                c_term = 8'hFF;
            end
            3: begin
                xo = 8'd255;
                xn = 8'd255;
            end
            4: begin
                xo = 8'd4;
                xn = 8'd2;
                h  = 1'b0;
            end
            5: begin
                xo = 8'd10;
                xn = 8'd8;
                s  = 1'b0;
                t  = 1'b0;
            end
            6: begin
                xo = 8'($urandom_range(0, DEPTH));
                xn = 8'($urandom_range(0, DEPTH));
                s  = 1'($urandom_range(0, 1));
                h  = 1'($urandom_range(0, 1));
                t  = 1'($urandom_range(0, 1));
            end
            default: begin
                xo = 8'($urandom_range(0, 255));
                xn = 8'($urandom_range(0, 255));
                s  = 1'($urandom_range(0, 1));
                h  = 1'($urandom_range(0, 1));
                t  = 1'($urandom_range(0, 1));
            end
        endcase
        cfg_write(urxflow_pkg::CFG_XOFF_LEVEL, xo);
        cfg_write(urxflow_pkg::CFG_XON_LEVEL, xn);
        cfg_write(urxflow_pkg::CFG_XON_CODE, c_on);
        cfg_write(urxflow_pkg::CFG_XOFF_CODE, c_off);
        cfg_write(urxflow_pkg::CFG_TERM_CODE, c_term);
        // Upper data bits of the enable registers carry noise that must be ignored.
        cfg_write(urxflow_pkg::CFG_SOFT_FLOW_EN, {7'($urandom_range(0, 127)), s});
        cfg_write(urxflow_pkg::CFG_HARD_FLOW_EN, {7'($urandom_range(0, 127)), h});
        cfg_write(urxflow_pkg::CFG_TERM_EN, {7'($urandom_range(0, 127)), t});
        cfg_write(CFG_SPARE_IDX, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int         left, len, burst, pick;
        logic [1:0] kind;
        logic [7:0] data;
        failed = 1'b0;
        calm   = 1'b0;
        pin_typed = 1'b0;
        pin_want  = '0;
        i_rst_n = 1'b0;
        rx_in.valid = 1'b0;
        rx_in.kind  = urxflow_pkg::KIND_RX;
        rx_in.data  = 8'h00;
        rx_in.send_valid = 1'b0;
        rx_in.thr_empty  = 1'b0;
        cfg_wr.valid = 1'b0;
        cfg_wr.index = urxflow_pkg::CFG_XOFF_LEVEL;
        cfg_wr.data  = 8'h00;
        clear_flow_state();

        // Reset values and field extremes; results here are obvious from the rules.
        add_row(urxflow_pkg::KIND_READ, 8'h00, 1'b0, 1'b1, 1'b1,
                pack_result(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'd0));
        add_row(urxflow_pkg::KIND_SLOT, 8'h5A, 1'b0, 1'b1, 1'b1,
                pack_result(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'd0));
        add_row(urxflow_pkg::KIND_SLOT, 8'hFF, 1'b1, 1'b0, 1'b1,
                pack_result(1'b1, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'd0));
        add_row(urxflow_pkg::KIND_SLOT, 8'h00, 1'b1, 1'b1, 1'b1,
                pack_result(1'b1, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'd0));
        add_row(KIND_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1,
                pack_result(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'd0));
        add_row(urxflow_pkg::KIND_RX, 8'h0A, 1'b0, 1'b1, 1'b1,
                pack_result(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'd1));
        add_row(urxflow_pkg::KIND_RX, 8'hFF, 1'b1, 1'b0, 1'b1,
                pack_result(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'd2));
        add_row(urxflow_pkg::KIND_RX, 8'h00, 1'b0, 1'b1, 1'b1,
                pack_result(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'd3));
        add_row(urxflow_pkg::KIND_READ, 8'h00, 1'b0, 1'b1, 1'b1,
                pack_result(1'b0, 8'h00, 1'b0, 1'b1, 8'h0A, 1'b1, 1'b1, 1'b0, 8'd2));
        add_row(urxflow_pkg::KIND_READ, 8'h00, 1'b0, 1'b0, 1'b1,
                pack_result(1'b0, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b1, 1'b0, 8'd1));
        add_row(urxflow_pkg::KIND_READ, 8'h00, 1'b0, 1'b1, 1'b1,
                pack_result(1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 8'd0));
        // Low thresholds: busy XOFF, direct XOFF, pending send, XON pending, both cancel.
        add_row(urxflow_pkg::KIND_RX, 8'h41, 1'b0, 1'b1, 1'b0, '0);
        add_row(urxflow_pkg::KIND_RX, 8'h42, 1'b0, 1'b1, 1'b0, '0);
        add_row(urxflow_pkg::KIND_RX, 8'h43, 1'b0, 1'b0, 1'b0, '0);
        add_row(urxflow_pkg::KIND_RX, 8'h0A, 1'b0, 1'b1, 1'b0, '0);
        add_row(urxflow_pkg::KIND_SLOT, 8'h55, 1'b1, 1'b1, 1'b0, '0);
        add_row(urxflow_pkg::KIND_SLOT, 8'h55, 1'b1, 1'b1, 1'b0, '0);
        add_row(urxflow_pkg::KIND_READ, 8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(urxflow_pkg::KIND_READ, 8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(urxflow_pkg::KIND_READ, 8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(urxflow_pkg::KIND_READ, 8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(urxflow_pkg::KIND_RX, 8'h01, 1'b0, 1'b1, 1'b0, '0);
        add_row(urxflow_pkg::KIND_RX, 8'h02, 1'b0, 1'b1, 1'b0, '0);
        add_row(urxflow_pkg::KIND_RX, 8'h03, 1'b0, 1'b0, 1'b0, '0);
        add_row(urxflow_pkg::KIND_SLOT, 8'hAA, 1'b1, 1'b1, 1'b0, '0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            if (i == DIR_SPLIT) begin
                wait_idle();
                cfg_write(urxflow_pkg::CFG_XOFF_LEVEL, 8'd2);
                cfg_write(urxflow_pkg::CFG_XON_LEVEL, 8'd1);
            end
            send_item(plan[i].kind, plan[i].data, plan[i].send_valid, plan[i].thr_empty,
                      plan[i].typed, plan[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            program_phase(phase);
            left = PHASE_ITEMS;
            while (left > 0) begin
                calm  = ($urandom_range(0, 3) == 0);
                burst = $urandom_range(0, 9);
                if (burst < 7)
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(130, 150)
                                                      : $urandom_range(5, 60);
                else
                    len = $urandom_range(5, 20);
                for (int j = 0; j < len; j++) begin
                    pick = $urandom_range(0, 99);
                    if (burst < 4)
                        kind = (pick < 85) ? urxflow_pkg::KIND_RX
                             : (pick < 95) ? urxflow_pkg::KIND_SLOT : urxflow_pkg::KIND_READ;
                    else if (burst < 7)
                        kind = (pick < 80) ? urxflow_pkg::KIND_READ
                             : (pick < 95) ? urxflow_pkg::KIND_SLOT : urxflow_pkg::KIND_RX;
                    else
                        kind = 2'($urandom_range(0, 3));
                    if (kind == urxflow_pkg::KIND_RX && $urandom_range(0, 3) == 0)
                        data = chr_term;
                    else
                        data = 8'($urandom_range(0, 255));
                    send_item(kind, data, 1'($urandom_range(0, 1)), ($urandom_range(0, 9) < 7),
                              1'b0, '0);
                end
                left -= len;
                // Occasionally hold the sender off until the output side has caught up.
                if ($urandom_range(0, 7) == 0) wait_idle();
            end
        end
        calm = 1'b0;
        wait_idle();
        repeat (10) @(negedge i_clk);

        if (!failed && due_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
